>>> design/dsp_adpcm_decoder_core_macros.svh
// Assertion macros shared by the checker files of the ADPCM decoder core.
`ifndef DSP_ADPCM_DECODER_CORE_MACROS_SVH
`define DSP_ADPCM_DECODER_CORE_MACROS_SVH

// Checked on every rising edge of clock outside reset.
`define DAP_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge of clock, reset included.
`define DAP_ASSERT_ALL(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> design/dap_pkg.sv
// Shared constants and types of the ADPCM decoder core.
package dap_pkg;

   localparam int NumCoefs         = 8;
   localparam int CoefBits         = 16;
   localparam int SampleBits       = 16;
   localparam int ByteBits         = 8;
   localparam int NibbleBits       = 4;
   localparam int CsrDataBits      = 2 * CoefBits;
   localparam int CsrIndexBits     = $clog2(NumCoefs);
   localparam int PredBits         = $clog2(NumCoefs);
   localparam int ShiftBits        = 4;
   localparam int FrameBits        = 3;
   localparam int BudgetBits       = 16;
   localparam int DefaultCountBits = 16;
   localparam int QueueDepth       = 4;

   // Prediction arithmetic: products, rounded sum and the final sample sum.
   localparam int ProdBits   = 2 * CoefBits;
   localparam int AccBits    = ProdBits + 2;
   localparam int RoundShift = 11;
   localparam int PredTermBits = AccBits - RoundShift;
   localparam int ResTermBits  = NibbleBits + (1 << ShiftBits) + 1;
   localparam int TotalBits    = PredTermBits + 1;

   localparam logic signed [AccBits-1:0]    RoundBias = AccBits'(1024);
   localparam logic [PredBits-1:0]          MaxPred   = PredBits'(7);
   localparam logic signed [TotalBits-1:0]  SatMax    = TotalBits'(32767);
   localparam logic signed [TotalBits-1:0]  SatMin   = -TotalBits'(32768);
   localparam logic signed [SampleBits-1:0] SampleMax = 16'sh7FFF;
   localparam logic signed [SampleBits-1:0] SampleMin = 16'sh8000;

   // Kind of work handed from the front to the back.
   typedef enum logic {
      OP_RESTART,
      OP_DECODE
   } op_type;

   // One queue entry: a history load or a byte worth one or two samples.
   typedef struct packed {
      op_type                        op;
      logic [ByteBits-1:0]           data_byte;
      logic                          two_samples;
      logic                          done_first;
      logic                          done_second;
      logic [PredBits-1:0]           pred;
      logic [ShiftBits-1:0]          shift;
      logic signed [SampleBits-1:0]  hist_recent;
      logic signed [SampleBits-1:0]  hist_older;
   } work_type;

   // Status of the work queue as seen by its neighbours.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

>>> design/dap_req_if.sv
// Input channel of the ADPCM decoder core: one stream byte or restart per beat.
interface dap_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  mode;
   logic [dap_pkg::ByteBits-1:0]          data_byte;
   logic signed [dap_pkg::SampleBits-1:0] hist_recent_in;
   logic signed [dap_pkg::SampleBits-1:0] hist_older_in;
   logic [dap_pkg::BudgetBits-1:0]        sample_budget;

   modport source (output valid, mode, data_byte, hist_recent_in, hist_older_in,
                   sample_budget, input ready);
   modport sink   (input valid, mode, data_byte, hist_recent_in, hist_older_in,
                   sample_budget, output ready);
endinterface

>>> design/dap_rsp_if.sv
// Result channel of the ADPCM decoder core: one decoded sample per beat.
interface dap_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [dap_pkg::SampleBits-1:0] pcm_sample;
   logic                                  last;
   logic                                  done_res;

   modport source (output valid, pcm_sample, last, done_res, input ready);
   modport sink   (input valid, pcm_sample, last, done_res, output ready);
endinterface

>>> design/dsp_adpcm_decoder_core.sv
// Top level of the DSP-ADPCM decoder core: coefficient registers, front, queue, back.
//
//   Channel  Dir  Handshake          Beat
//   req_ch   in   valid/ready        one stream byte or a restart
//   rsp_ch   out  valid/ready        one decoded 16-bit sample
//   csr_*    in   csr_we             one 32-bit coefficient pair
//
// A beat is taken every cycle while the four-entry work queue has room.
// Each sample of a data byte passes the back end as a multiply step and then a
// sum-and-saturate step, which waits while the result register is full; headers
// and bytes past the budget never reach it, and a restart only loads the history.
// Reset is synchronous and clears all control state and history at once.
// A stalled result holds in the output register while the queue keeps filling.
module dsp_adpcm_decoder_core #(
   parameter int COUNT_BITS = dap_pkg::DefaultCountBits
) (
   input  logic                               clock,
   input  logic                               reset,
   dap_req_if.sink                            req_ch,
   dap_rsp_if.source                          rsp_ch,
   input  logic                               csr_we,
   input  logic [dap_pkg::CsrIndexBits-1:0]   csr_index,
   input  logic [dap_pkg::CsrDataBits-1:0]    csr_wdata
);

   logic [dap_pkg::NumCoefs-1:0][dap_pkg::CsrDataBits-1:0] coef_ff;
   dap_pkg::queue_status_type q_status;
   dap_pkg::work_type         push_entry;
   dap_pkg::work_type         head;
   logic                      push;
   logic                      pop;

   // Coefficient pair registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (csr_we) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   dap_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   dap_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   dap_back u_back (
      .clock      (clock),
      .reset      (reset),
      .coef       (coef_ff),
      .head       (head),
      .head_valid (!q_status.empty),
      .pop        (pop),
      .rsp        (rsp_ch)
   );

endmodule

>>> design/dap_front.sv
// Front end: accepts beats, tracks frame position, header and sample budget.
module dap_front #(
   parameter int COUNT_BITS = dap_pkg::DefaultCountBits
) (
   input  logic                      clock,
   input  logic                      reset,
   dap_req_if.sink                   req,
   input  dap_pkg::queue_status_type q_status,
   output logic                      push,
   output dap_pkg::work_type         push_entry
);

   logic [dap_pkg::FrameBits-1:0] frame_ff, frame_in;
   logic [dap_pkg::PredBits-1:0]  pred_ff, pred_in;
   logic [dap_pkg::ShiftBits-1:0] shift_ff, shift_in;
   logic [COUNT_BITS-1:0]         left_ff, left_in;

   logic                          accept;
   logic                          left_zero;
   logic                          left_one;
   logic                          left_two;
   logic [1:0]                    take_cnt;
   logic [dap_pkg::NibbleBits-1:0] hi_nib;

   // A beat is taken whenever the queue has room for what it may cause.
   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;
   assign hi_nib    = req.data_byte[dap_pkg::ByteBits-1 -: dap_pkg::NibbleBits];

   // How many samples the budget still allows for one data byte.
   assign left_zero = (left_ff == '0);
   assign left_one  = (left_ff == COUNT_BITS'(1));
   assign left_two  = (left_ff == COUNT_BITS'(2));
   assign take_cnt  = left_zero ? 2'd0 : (left_one ? 2'd1 : 2'd2);

   // Classify the beat and work out the front state that follows it.
   always_comb begin
      frame_in   = frame_ff;
      pred_in    = pred_ff;
      shift_in   = shift_ff;
      left_in    = left_ff;
      push       = 1'b0;
      push_entry.op          = dap_pkg::OP_DECODE;
      push_entry.data_byte   = req.data_byte;
      push_entry.two_samples = (take_cnt == 2'd2);
      push_entry.done_first  = left_one;
      push_entry.done_second = left_two;
      push_entry.pred        = pred_ff;
      push_entry.shift       = shift_ff;
      push_entry.hist_recent = req.hist_recent_in;
      push_entry.hist_older  = req.hist_older_in;
      if (accept) begin
         priority if (req.mode) begin
            // Restart: new budget here, new history in the back end.
            left_in       = COUNT_BITS'(req.sample_budget);
            frame_in      = '0;
            push          = 1'b1;
            push_entry.op = dap_pkg::OP_RESTART;
         end else if (frame_ff == '0) begin
            // Header byte: predictor (clamped) and scale shift.
            pred_in  = hi_nib[dap_pkg::NibbleBits-1] ? dap_pkg::MaxPred
                                                      : hi_nib[dap_pkg::PredBits-1:0];
            shift_in = req.data_byte[dap_pkg::ShiftBits-1:0];
            frame_in = frame_ff + 1'b1;
         end else begin
            // Data byte: spend the budget; a byte past the budget is dropped.
            left_in  = left_ff - COUNT_BITS'(take_cnt);
            frame_in = frame_ff + 1'b1;
            push     = !left_zero;
         end
      end
   end

   // Front state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         pred_ff  <= '0;
         shift_ff <= '0;
         left_ff  <= '0;
      end else begin
         frame_ff <= frame_in;
         pred_ff  <= pred_in;
         shift_ff <= shift_in;
         left_ff  <= left_in;
      end
   end

endmodule

>>> design/dap_queue.sv
// Short first-in first-out queue of work entries between front and back end.
module dap_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  dap_pkg::work_type         push_entry,
   input  logic                      pop,
   output dap_pkg::work_type         head,
   output dap_pkg::queue_status_type status
);

   localparam int PtrBits   = $clog2(dap_pkg::QueueDepth);
   localparam int CountBits = $clog2(dap_pkg::QueueDepth + 1);

   dap_pkg::work_type     entry_ff [dap_pkg::QueueDepth];
   logic [PtrBits-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0]  count_ff, count_in;

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CountBits'(dap_pkg::QueueDepth));
   assign status.empty = (count_ff == '0);

   // Pointer and fill level updates.
   always_comb begin
      wr_ptr_in = push ? PtrBits'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PtrBits'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + CountBits'(push) - CountBits'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> design/dap_back.sv
// Back end: two-tap prediction, residual scaling, saturation and result register.
module dap_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [dap_pkg::NumCoefs-1:0][dap_pkg::CsrDataBits-1:0] coef,
   input  dap_pkg::work_type         head,
   input  logic                      head_valid,
   output logic                      pop,
   dap_rsp_if.source                 rsp
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD
   } state_type;

   state_type                              state_ff, state_in;
   logic signed [dap_pkg::SampleBits-1:0]  hist_recent_ff, hist_recent_in;
   logic signed [dap_pkg::SampleBits-1:0]  hist_older_ff, hist_older_in;
   logic [dap_pkg::ByteBits-1:0]           byte_ff, byte_in;
   logic                                   two_ff, two_in;
   logic                                   done1_ff, done1_in;
   logic                                   done2_ff, done2_in;
   logic [dap_pkg::PredBits-1:0]           pred_ff, pred_in;
   logic [dap_pkg::ShiftBits-1:0]          shift_ff, shift_in;
   logic                                   sel_ff, sel_in;
   logic signed [dap_pkg::ProdBits-1:0]    prod0_ff, prod0_in;
   logic signed [dap_pkg::ProdBits-1:0]    prod1_ff, prod1_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic signed [dap_pkg::SampleBits-1:0]  rsp_pcm_ff, rsp_pcm_in;
   logic                                   rsp_last_ff, rsp_last_in;
   logic                                   rsp_done_ff, rsp_done_in;

   logic [dap_pkg::CsrDataBits-1:0]          pair;
   logic signed [dap_pkg::CoefBits-1:0]      c0;
   logic signed [dap_pkg::CoefBits-1:0]      c1;
   logic signed [dap_pkg::AccBits-1:0]       acc;
   logic signed [dap_pkg::PredTermBits-1:0]  pred_term;
   logic [dap_pkg::NibbleBits-1:0]           nib;
   logic signed [dap_pkg::ResTermBits-1:0]   res_term;
   logic signed [dap_pkg::TotalBits-1:0]     total;
   logic signed [dap_pkg::SampleBits-1:0]    sample;
   logic                                     out_free;
   logic                                     finish;
   logic                                     take;

   // Coefficients of the predictor chosen by the current frame header.
   assign pair = coef[pred_ff];
   assign c0   = pair[dap_pkg::CsrDataBits-1 -: dap_pkg::CoefBits];
   assign c1   = pair[dap_pkg::CoefBits-1:0];

   // Rounded prediction: floor((c0*h1 + c1*h2 + 1024) / 2048).
   assign acc       = prod0_ff + prod1_ff + dap_pkg::RoundBias;
   assign pred_term = acc[dap_pkg::AccBits-1:dap_pkg::RoundShift];

   // Residual: high nibble first, sign-extended and scaled by the shift.
   assign nib      = sel_ff ? byte_ff[dap_pkg::NibbleBits-1:0]
                            : byte_ff[dap_pkg::ByteBits-1 -: dap_pkg::NibbleBits];
   assign res_term = {{(dap_pkg::ResTermBits - dap_pkg::NibbleBits){nib[dap_pkg::NibbleBits-1]}},
                      nib} <<< shift_ff;
   assign total    = pred_term + res_term;

   // Saturate to the sample range.
   always_comb begin
      priority if (total > dap_pkg::SatMax) begin
         sample = dap_pkg::SampleMax;
      end else if (total < dap_pkg::SatMin) begin
         sample = dap_pkg::SampleMin;
      end else begin
         sample = total[dap_pkg::SampleBits-1:0];
      end
   end

   // The result register is free when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign finish   = (state_ff == ST_ADD) && out_free && (sel_ff || !two_ff);
   assign take     = (state_ff == ST_IDLE) || finish;
   assign pop      = take && head_valid;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.pcm_sample = rsp_pcm_ff;
   assign rsp.last       = rsp_last_ff;
   assign rsp.done_res   = rsp_done_ff;

   // Next-state logic of the sample sequencer.
   always_comb begin
      state_in       = state_ff;
      hist_recent_in = hist_recent_ff;
      hist_older_in  = hist_older_ff;
      byte_in        = byte_ff;
      two_in         = two_ff;
      done1_in       = done1_ff;
      done2_in       = done2_ff;
      pred_in        = pred_ff;
      shift_in       = shift_ff;
      sel_in         = sel_ff;
      prod0_in       = prod0_ff;
      prod1_in       = prod1_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_pcm_in     = rsp_pcm_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_done_in    = rsp_done_ff;

      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_MUL: begin
            prod0_in = c0 * hist_recent_ff;
            prod1_in = c1 * hist_older_ff;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_pcm_in     = sample;
               rsp_last_in    = sel_ff || !two_ff;
               rsp_done_in    = sel_ff ? done2_ff : done1_ff;
               hist_older_in  = hist_recent_ff;
               hist_recent_in = sample;
               if (!finish) begin
                  sel_in   = 1'b1;
                  state_in = ST_MUL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Pick up the next queue entry as soon as the previous one is through.
      if (take) begin
         state_in = ST_IDLE;
         if (head_valid) begin
            unique case (head.op)
               dap_pkg::OP_RESTART: begin
                  hist_recent_in = head.hist_recent;
                  hist_older_in  = head.hist_older;
               end
               dap_pkg::OP_DECODE: begin
                  byte_in  = head.data_byte;
                  two_in   = head.two_samples;
                  done1_in = head.done_first;
                  done2_in = head.done_second;
                  pred_in  = head.pred;
                  shift_in = head.shift;
                  sel_in   = 1'b0;
                  state_in = ST_MUL;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
      end
   end

   // State, history and the registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         hist_recent_ff <= '0;
         hist_older_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         hist_recent_ff <= hist_recent_in;
         hist_older_ff  <= hist_older_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      byte_ff     <= byte_in;
      two_ff      <= two_in;
      done1_ff    <= done1_in;
      done2_ff    <= done2_in;
      pred_ff     <= pred_in;
      shift_ff    <= shift_in;
      sel_ff      <= sel_in;
      prod0_ff    <= prod0_in;
      prod1_ff    <= prod1_in;
      rsp_pcm_ff  <= rsp_pcm_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

endmodule

>>> design/dap_checker.sv
// Port checker of the ADPCM decoder core and its bind to the top level.
`include "dsp_adpcm_decoder_core_macros.svh"

module dap_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [dap_pkg::SampleBits-1:0]     rsp_pcm_sample,
   input logic                               rsp_last,
   input logic                               rsp_done_res
);

   // A stalled result beat keeps its sample.
   `DAP_ASSERT_RST(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pcm_sample), "stalled result changed")

   // The sample that spends the budget is always the last one of its byte.
   `DAP_ASSERT_RST(a_done_is_last, rsp_valid && rsp_done_res |-> rsp_last, "budget end without last")

   // No result is offered in the cycle after reset.
   `DAP_ASSERT_ALL(a_reset_quiet, $past(reset) |-> !rsp_valid, "result offered after reset")

endmodule

bind dsp_adpcm_decoder_core dap_checker u_dap_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_pcm_sample (rsp_ch.pcm_sample),
   .rsp_last       (rsp_ch.last),
   .rsp_done_res   (rsp_ch.done_res)
);
